>>> design/hamd_pkg.sv
package hamd_pkg;

  localparam int LANES      = 8;
  localparam int SLOT_W     = 6;
  localparam int RGB_W      = 24;
  localparam int COL_W      = 9;
  localparam int PLANES_W   = 64;
  localparam int XPOS_W     = 12;
  localparam int CIDX_W     = 6;
  localparam int WIDTH_W    = 13;
  localparam int PCOUNT_W   = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXELS  = 1'b1;

  localparam logic [1:0] CTRL_PALETTE = 2'd0;
  localparam logic [1:0] CTRL_BLUE    = 2'd1;
  localparam logic [1:0] CTRL_RED     = 2'd2;
  localparam logic [1:0] CTRL_GREEN   = 2'd3;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_PLANE_COUNT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd320;
  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 4'd6;
  localparam logic [PCOUNT_W-1:0] PCOUNT_MIN   = 4'd5;
  localparam logic [PCOUNT_W-1:0] PCOUNT_MAX   = 4'd8;

  typedef struct packed {
    logic [PCOUNT_W-1:0] np;
    logic [2:0]          cbits;
  } lane_cfg_t;

  typedef struct packed {
    logic              live;
    logic [1:0]        ctrl;
    logic [CIDX_W-1:0] cidx;
    logic [7:0]        expv;
  } lane_op_t;

  typedef struct packed {
    logic                       req;
    logic [SLOT_W-1:0]          slot;
    logic [RGB_W-1:0]           rgb;
    logic [COL_W-1:0]           col;
    lane_op_t [LANES-1:0]       ops;
  } item_t;

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [XPOS_W-1:0] pixel_x;
    logic              last_pixel;
  } pixel_t;

endpackage

>>> design/hamd_in_if.sv
interface hamd_in_if;
  import hamd_pkg::*;

  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SLOT_W-1:0]   palette_slot;
  logic [RGB_W-1:0]    palette_rgb;
  logic [COL_W-1:0]    byte_column;
  logic [PLANES_W-1:0] plane_bytes;

  modport source (
    output valid, req_type, palette_slot, palette_rgb, byte_column, plane_bytes,
    input  ready
  );

  modport sink (
    input  valid, req_type, palette_slot, palette_rgb, byte_column, plane_bytes,
    output ready
  );

endinterface

>>> design/hamd_out_if.sv
interface hamd_out_if;
  import hamd_pkg::*;

  logic              valid;
  logic              ready;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic [XPOS_W-1:0] pixel_x;
  logic              last_pixel;

  modport source (
    output valid, red, green, blue, pixel_x, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, pixel_x, last_pixel,
    output ready
  );

endinterface

>>> design/hamd_ram.sv
module hamd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/hamd_lane.sv
module hamd_lane #(
  parameter int unsigned BIT_POS        = 0,
  parameter int unsigned MAX_ROW_PIXELS = 4096
) (
  input  logic [hamd_pkg::PLANES_W-1:0] plane_bytes,
  input  logic [hamd_pkg::COL_W-1:0]    byte_column,
  input  logic [hamd_pkg::WIDTH_W-1:0]  image_width,
  input  hamd_pkg::lane_cfg_t           cfg,
  output hamd_pkg::lane_op_t            op
);
  import hamd_pkg::*;

  logic [7:0]        pix;
  logic [CIDX_W-1:0] c;
  logic [XPOS_W-1:0] x;

  always_comb begin
    for (int p = 0; p < 8; p++) begin
      pix[p] = (4'(p) < cfg.np) && plane_bytes[8*p + 7 - int'(BIT_POS)];
    end
  end

  assign c = CIDX_W'(pix & ((8'd1 << cfg.cbits) - 8'd1));
  assign x = {byte_column, 3'(BIT_POS)};

  always_comb begin
    op.live = ({1'b0, x} < image_width) && (32'(x) < 32'(MAX_ROW_PIXELS));
    op.ctrl = 2'(pix >> cfg.cbits);
    op.cidx = c;
    if (cfg.cbits == 3'd4) begin
      op.expv = {c[3:0], c[3:0]};
    end else begin
      op.expv = {c, 2'b00} | {6'b0, c[5:4]};
    end
  end

endmodule

>>> design/hamd_merge.sv
module hamd_merge #(
  parameter int PALETTE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  hamd_pkg::item_t   item,
  output logic              item_ready,
  output logic              pix_valid,
  input  logic              pix_ready,
  output hamd_pkg::pixel_t  pix
);
  import hamd_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic                      it_valid_r;
  item_t                     it_r;
  logic [2:0]                k_r;
  logic [PALETTE_DEPTH-1:0]  pv_r;

  logic                      a_valid_r;
  logic                      a_emit_r;
  logic                      a_clr_r;
  logic [1:0]                a_ctrl_r;
  logic [7:0]                a_expv_r;
  logic                      a_pal_ok_r;
  logic [XPOS_W-1:0]         a_x_r;
  logic                      a_last_r;

  logic [RGB_W-1:0]          held_r;
  logic                      o_valid_r;
  pixel_t                    o_r;

  lane_op_t                  cur;
  logic                      next_live;
  logic                      is_pal;
  logic                      col0;
  logic                      has_op;
  logic                      adv;
  logic                      send;
  logic                      done;
  logic                      take;
  logic                      wr_en;
  logic                      idx_ok;
  logic [AW-1:0]             rd_addr;
  logic [RGB_W-1:0]          rd_data;
  logic                      apply_fire;
  logic [RGB_W-1:0]          base;
  logic [RGB_W-1:0]          pal;
  logic [RGB_W-1:0]          held_nxt;

  assign cur       = it_r.ops[k_r];
  assign next_live = (k_r == 3'd7) ? 1'b0 : it_r.ops[3'(k_r + 3'd1)].live;
  assign is_pal    = (it_r.req == REQ_PALETTE);
  assign col0      = (it_r.col == '0);
  assign has_op    = cur.live || (col0 && (k_r == 3'd0));

  assign apply_fire = a_valid_r && (!o_valid_r || pix_ready);
  assign adv        = !a_valid_r || apply_fire;
  assign send       = it_valid_r && !is_pal && has_op && adv;
  assign done       = it_valid_r &&
                      (is_pal || !has_op || (adv && !(cur.live && next_live)));
  assign item_ready = !it_valid_r || done;
  assign take       = item_valid && item_ready;

  assign wr_en   = it_valid_r && is_pal && (32'(it_r.slot) < 32'(PALETTE_DEPTH));
  assign idx_ok  = (32'(cur.cidx) < 32'(PALETTE_DEPTH));
  assign rd_addr = cur.cidx[AW-1:0];

  hamd_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (it_r.slot[AW-1:0]),
    .wdata (it_r.rgb),
    .re    (send),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_valid_r <= 1'b0;
      k_r        <= '0;
      pv_r       <= '0;
    end else begin
      if (take) begin
        it_valid_r <= 1'b1;
        k_r        <= '0;
      end else if (done) begin
        it_valid_r <= 1'b0;
      end else if (send) begin
        k_r <= 3'(k_r + 3'd1);
      end
      if (wr_en) begin
        pv_r[it_r.slot[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      it_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= send;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      a_emit_r   <= cur.live;
      a_clr_r    <= col0 && (k_r == 3'd0);
      a_ctrl_r   <= cur.ctrl;
      a_expv_r   <= cur.expv;
      a_pal_ok_r <= idx_ok && pv_r[rd_addr];
      a_x_r      <= {it_r.col, k_r};
      a_last_r   <= !next_live;
    end
  end

  assign base = a_clr_r ? '0 : held_r;
  assign pal  = a_pal_ok_r ? rd_data : '0;

  always_comb begin
    unique case (a_ctrl_r)
      CTRL_PALETTE: held_nxt = pal;
      CTRL_BLUE:    held_nxt = {base[23:8], a_expv_r};
      CTRL_RED:     held_nxt = {a_expv_r, base[15:0]};
      CTRL_GREEN:   held_nxt = {base[23:16], a_expv_r, base[7:0]};
      default:      held_nxt = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      o_valid_r <= 1'b0;
    end else begin
      if (apply_fire) begin
        held_r <= a_emit_r ? held_nxt : '0;
      end
      if (apply_fire && a_emit_r) begin
        o_valid_r <= 1'b1;
      end else if (pix_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire && a_emit_r) begin
      o_r.red        <= held_nxt[23:16];
      o_r.green      <= held_nxt[15:8];
      o_r.blue       <= held_nxt[7:0];
      o_r.pixel_x    <= a_x_r;
      o_r.last_pixel <= a_last_r;
    end
  end

  assign pix_valid = o_valid_r;
  assign pix       = o_r;

endmodule

>>> design/hold_and_modify_pixel_decoder.sv
// Hold-and-modify bitplane pixel decoder.
// in_chan (valid/ready) takes one transaction per item: req_type 0 writes
// palette_rgb into palette slot palette_slot; req_type 1 brings one byte per
// bitplane at byte_column and yields up to eight pixels, leftmost first.
// out_chan (valid/ready) gives one pixel per transaction with its pixel_x;
// last_pixel marks the final pixel of an item.
// Eight lanes decode the item's pixels at once; a serializer then applies
// them one per cycle, while out_chan is not stalled, to the held colour,
// reading the palette RAM in the issue stage ahead of the apply stage.
// Each pixel passes the item register, the issue stage and the apply
// stage before it shows. The next item is taken while the current one
// drains.
// When out_chan stalls, the serializer holds and in_chan stops accepting
// once a pixel item waits. The APB port (cfg_*) writes image_width at 0
// and plane_count at 4; write only while the block is idle.
// Synchronous reset sets image_width to 320, plane_count to 6, clears the
// held colour and marks every palette slot black; no clearing pass is run.
module hold_and_modify_pixel_decoder #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int PALETTE_DEPTH  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hamd_in_if.sink                       in_chan,
  hamd_out_if.source                    out_chan,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [hamd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [hamd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [hamd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import hamd_pkg::*;

  logic [WIDTH_W-1:0]   image_width_r;
  logic [PCOUNT_W-1:0]  plane_count_r;
  logic                 cfg_wr;
  lane_cfg_t            lcfg;
  lane_op_t [LANES-1:0] lane_ops;
  item_t                item;
  pixel_t               pix;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= WIDTH_RESET;
      plane_count_r <= PCOUNT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_IMAGE_WIDTH: image_width_r <= cfg_pwdata[WIDTH_W-1:0];
        REG_PLANE_COUNT: plane_count_r <= cfg_pwdata[PCOUNT_W-1:0];
        default:         image_width_r <= image_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_IMAGE_WIDTH: cfg_prdata = CFG_DATA_W'(image_width_r);
      REG_PLANE_COUNT: cfg_prdata = CFG_DATA_W'(plane_count_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (plane_count_r < PCOUNT_MIN) begin
      lcfg.np = PCOUNT_MIN;
    end else if (plane_count_r > PCOUNT_MAX) begin
      lcfg.np = PCOUNT_MAX;
    end else begin
      lcfg.np = plane_count_r;
    end
    lcfg.cbits = 3'(lcfg.np - 4'd2);
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    hamd_lane #(
      .BIT_POS        (i),
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_lane (
      .plane_bytes (in_chan.plane_bytes),
      .byte_column (in_chan.byte_column),
      .image_width (image_width_r),
      .cfg         (lcfg),
      .op          (lane_ops[i])
    );
  end

  always_comb begin
    item.req  = in_chan.req_type;
    item.slot = in_chan.palette_slot;
    item.rgb  = in_chan.palette_rgb;
    item.col  = in_chan.byte_column;
    item.ops  = lane_ops;
  end

  hamd_merge #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_chan.valid),
    .item       (item),
    .item_ready (in_chan.ready),
    .pix_valid  (out_chan.valid),
    .pix_ready  (out_chan.ready),
    .pix        (pix)
  );

  assign out_chan.red        = pix.red;
  assign out_chan.green      = pix.green;
  assign out_chan.blue       = pix.blue;
  assign out_chan.pixel_x    = pix.pixel_x;
  assign out_chan.last_pixel = pix.last_pixel;

endmodule
